### design/msmg_pkg.sv
// shared constants and types of the median soft-mask gain block
// no dependencies
package msmg_pkg;

  localparam int unsigned MaxBinsDef  = 2049;
  localparam int unsigned TimeTapsDef = 9;
  localparam int unsigned FreqTapsDef = 17;
  localparam int unsigned MagBitsDef  = 24;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned BinOutBits = 12;
  localparam int unsigned GainBits   = 16;
  localparam int unsigned FracBits   = 16;

  localparam logic [CfgIdxBits-1:0] RegBinCount   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegTonalGain  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegAttackGain = 2'd2;

  localparam logic [11:0] BinCountRst = 12'd2049;
  localparam logic [15:0] GainRst     = 16'd16384;

  typedef struct packed {
    logic [GainBits-1:0] gain;
    logic [FracBits-1:0] tonal;
    logic [FracBits-1:0] attack;
  } msmg_res_t;

endpackage

### design/msmg_ram.sv
// generic single write, single registered read RAM
// no dependencies
module msmg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/msmg_sort_cell.sv
// one cell of the insertion sorting chain: keeps the smaller value, passes the larger on
// no dependencies
module msmg_sort_cell #(
  parameter int unsigned W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clear_i,
  input  logic         in_valid_i,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  output logic [W-1:0] out_data_o,
  output logic [W-1:0] value_o
);

  logic         full_q;
  logic [W-1:0] val_q;
  logic         pv_q;
  logic [W-1:0] pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      pv_q   <= 1'b0;
    end else if (clear_i) begin
      full_q <= 1'b0;
      pv_q   <= 1'b0;
    end else begin
      pv_q <= 1'b0;
      if (in_valid_i) begin
        if (!full_q) begin
          full_q <= 1'b1;
          val_q  <= in_data_i;
        end else begin
          pv_q <= 1'b1;
          if (in_data_i < val_q) begin
            val_q <= in_data_i;
            pd_q  <= val_q;
          end else begin
            pd_q <= in_data_i;
          end
        end
      end
    end
  end

  assign out_valid_o = pv_q;
  assign out_data_o  = pd_q;
  assign value_o     = val_q;

endmodule

### design/msmg_median.sv
// median by a chain of sorting cells, one value fed per beat
// depends on msmg_sort_cell
module msmg_median #(
  parameter int unsigned N = 9,
  parameter int unsigned W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clear_i,
  input  logic         in_valid_i,
  input  logic [W-1:0] in_data_i,
  output logic [W-1:0] median_o
);

  logic         cv [N+1];
  logic [W-1:0] cd [N+1];
  logic [W-1:0] cval [N];

  assign cv[0] = in_valid_i;
  assign cd[0] = in_data_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    msmg_sort_cell #(.W(W)) u_cell (
      .clk_i,
      .rst_ni,
      .clear_i,
      .in_valid_i  (cv[i]),
      .in_data_i   (cd[i]),
      .out_valid_o (cv[i+1]),
      .out_data_o  (cd[i+1]),
      .value_o     (cval[i])
    );
  end

  assign median_o = cval[N/2];

endmodule

### design/msmg_mask.sv
// soft masks from the two medians and the resulting gain, iterative divide
// depends on msmg_pkg
module msmg_mask
  import msmg_pkg::*;
#(
  parameter int unsigned MAG_BITS = MagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MAG_BITS-1:0] h_i,
  input  logic [MAG_BITS-1:0] p_i,
  input  logic [CfgBits-1:0]  tonal_gain_i,
  input  logic [CfgBits-1:0]  attack_gain_i,
  output logic                done_o,
  output msmg_res_t           res_o
);

  localparam int unsigned NB  = (MAG_BITS > 30) ? 30 : MAG_BITS;
  localparam int unsigned NB2 = 2 * NB;
  localparam int unsigned DW  = 2 * NB + 3;

  typedef enum logic [2:0] {
    M_IDLE, M_NORM, M_SQ, M_DEN, M_DIV, M_CAP, M_PROD, M_SUM
  } mstate_e;

  mstate_e                state_q;
  logic [MAG_BITS-1:0]    h_q, p_q;
  logic                   zero_q;
  logic [2*NB-1:0]        h2_q, p2_q;
  logic [DW-1:0]          dent_q, dena_q, rt_q, ra_q;
  logic [16:0]            qt_q, qa_q;
  logic [4:0]             it_q;
  logic [16:0]            t_q, a_q;
  logic signed [34:0]     pt_q, pa_q;
  logic                   done_q;
  msmg_res_t              res_q;

  logic [32:0]            hw, pw;
  logic                   over;
  logic [NB-1:0]          hn, pn;
  logic [DW:0]            st, sa;
  logic                   get, gea;
  logic [16:0]            tc, ac, arem;
  logic signed [16:0]     tgs, ags;
  logic signed [36:0]     acc, accr;
  logic [20:0]            gq;

  always_comb begin
    hw   = 33'(h_q);
    pw   = 33'(p_q);
    over = (|hw[32:30]) || (|pw[32:30]);
    hn   = h_q[NB-1:0];
    pn   = p_q[NB-1:0];
    st   = (it_q == 5'd0) ? {1'b0, rt_q} : {rt_q, 1'b0};
    sa   = (it_q == 5'd0) ? {1'b0, ra_q} : {ra_q, 1'b0};
    get  = st >= {1'b0, dent_q};
    gea  = sa >= {1'b0, dena_q};
    tc   = zero_q ? 17'd0 : ((qt_q > 17'd65536) ? 17'd65536 : qt_q);
    arem = 17'd65536 - tc;
    ac   = zero_q ? 17'd0 : ((qa_q > arem) ? arem : qa_q);
    tgs  = $signed({1'b0, tonal_gain_i}) - 17'sd16384;
    ags  = $signed({1'b0, attack_gain_i}) - 17'sd16384;
    acc  = 37'sd1073741824 + 37'(pt_q) + 37'(pa_q);
    accr = acc + 37'sd32768;
    gq   = accr[36:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            h_q     <= h_i;
            p_q     <= p_i;
            zero_q  <= (h_i == '0) && (p_i == '0);
            state_q <= M_NORM;
          end
        end
        M_NORM: begin
          if (over) begin
            h_q <= h_q >> 1;
            p_q <= p_q >> 1;
          end else begin
            state_q <= M_SQ;
          end
        end
        M_SQ: begin
          h2_q    <= NB2'(hn) * NB2'(hn);
          p2_q    <= NB2'(pn) * NB2'(pn);
          state_q <= M_DEN;
        end
        M_DEN: begin
          dent_q  <= DW'(h2_q) + (DW'(p2_q) << 2);
          dena_q  <= DW'(p2_q) + (DW'(h2_q) << 2);
          rt_q    <= DW'(h2_q);
          ra_q    <= DW'(p2_q);
          qt_q    <= '0;
          qa_q    <= '0;
          it_q    <= '0;
          state_q <= M_DIV;
        end
        M_DIV: begin
          rt_q <= get ? DW'(st - {1'b0, dent_q}) : DW'(st);
          ra_q <= gea ? DW'(sa - {1'b0, dena_q}) : DW'(sa);
          qt_q <= {qt_q[15:0], get};
          qa_q <= {qa_q[15:0], gea};
          it_q <= it_q + 5'd1;
          if (it_q == 5'd16) begin
            state_q <= M_CAP;
          end
        end
        M_CAP: begin
          t_q     <= tc;
          a_q     <= ac;
          state_q <= M_PROD;
        end
        M_PROD: begin
          pt_q    <= 35'(tgs) * 35'($signed({1'b0, t_q}));
          pa_q    <= 35'(ags) * 35'($signed({1'b0, a_q}));
          state_q <= M_SUM;
        end
        M_SUM: begin
          if (acc < 0) begin
            res_q.gain <= '0;
          end else if (gq > 21'd65535) begin
            res_q.gain <= 16'hFFFF;
          end else begin
            res_q.gain <= gq[15:0];
          end
          res_q.tonal  <= t_q[16] ? 16'hFFFF : t_q[15:0];
          res_q.attack <= a_q[16] ? 16'hFFFF : a_q[15:0];
          done_q       <= 1'b1;
          state_q      <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == M_SUM)
    else $error("mask done without final step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == M_DIV |-> it_q <= 5'd16)
    else $error("divide ran past its last step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == M_PROD |-> {1'b0, t_q} + {1'b0, a_q} <= 18'd65536)
    else $error("masks sum above one");

endmodule

### design/median_soft_mask_gain_unit.sv
// median soft-mask gain: one beat per bin in, gains out lagging by FREQ_TAPS/2 bins
// each result: the time and frequency medians are fed, the mask unit computes the gain (more
// shift steps when MAG_BITS > 30), then the output is loaded, held off by output stalls;
// a new beat waits for all results of the last, up to FREQ_TAPS/2+1 on a frame's last bin
// after reset the history RAM is zero-filled, MAX_BINS*TIME_TAPS words (18441), input held
// off meanwhile; configuration resets to 2049 bins and unity gains
module median_soft_mask_gain_unit
  import msmg_pkg::*;
#(
  parameter int unsigned MAX_BINS  = MaxBinsDef,
  parameter int unsigned TIME_TAPS = TimeTapsDef,
  parameter int unsigned FREQ_TAPS = FreqTapsDef,
  parameter int unsigned MAG_BITS  = MagBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MAG_BITS-1:0]   magnitude_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BinOutBits-1:0] bin_index_o,
  output logic [GainBits-1:0]   gain_o,
  output logic [FracBits-1:0]   tonal_fraction_o,
  output logic [FracBits-1:0]   attack_fraction_o,
  output logic                  frame_last_o
);

  localparam int unsigned DEPTH = MAX_BINS * TIME_TAPS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(MAX_BINS);
  localparam int unsigned WW    = ((BW > 12) ? BW : 12) + 1;
  localparam int unsigned SLW   = $clog2(TIME_TAPS);
  localparam int unsigned FIW   = $clog2(FREQ_TAPS);
  localparam int unsigned LAG   = FREQ_TAPS / 2;
  localparam int unsigned NMAX  = (TIME_TAPS > FREQ_TAPS) ? TIME_TAPS : FREQ_TAPS;
  localparam int unsigned KEND  = 2 * NMAX + 3;
  localparam int unsigned KW    = $clog2(KEND + 1);
  localparam int unsigned SW    = BW + 3;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_FEED, S_MASK, S_OUT} state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [11:0]         bin_count_q;
  logic [CfgBits-1:0]  tonal_gain_q, attack_gain_q;
  logic [BW-1:0]       bin_ctr_q, b_q, c_q, cend_q;
  logic [SLW-1:0]      slot_q;
  logic                flush_q;
  logic [KW-1:0]       k_q;
  logic [MAG_BITS-1:0] win_q [FREQ_TAPS];
  logic [MAG_BITS-1:0] fval_q;
  logic                tv_q, fv_q;
  logic                out_valid_q, last_q;
  logic [BinOutBits-1:0] bin_q;
  msmg_res_t           outres_q;

  logic                accept;
  logic [WW-1:0]       n_raw, n_cl, b_ext, c_ext;
  logic [BW-1:0]       b_in;
  logic                last_in;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAG_BITS-1:0] ram_wdata, ram_rdata;
  logic signed [SW-1:0] nb;
  logic [BW-1:0]       nbu, nb_dist;
  logic [MAG_BITS-1:0] fsel;
  logic                feeding, sort_clear, mask_start, mask_done, load_out;
  logic [MAG_BITS-1:0] h_med, p_med;
  msmg_res_t           mres;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    n_raw   = WW'(bin_count_q);
    if (n_raw == '0) begin
      n_cl = WW'(1);
    end else if (n_raw > WW'(MAX_BINS)) begin
      n_cl = WW'(MAX_BINS);
    end else begin
      n_cl = n_raw;
    end
    b_in    = bin_ctr_q;
    b_ext   = WW'(b_in);
    last_in = (b_ext + WW'(1)) >= n_cl;
    c_ext   = WW'(c_q);
  end

  // history RAM port selection
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accept;
      ram_waddr = AW'(b_in) * AW'(TIME_TAPS) + AW'(slot_q);
      ram_wdata = magnitude_i;
    end
    ram_raddr = AW'(c_q) * AW'(TIME_TAPS) + AW'(k_q);
  end

  // frequency neighbour, clamped at the frame edges
  always_comb begin
    nb = $signed(SW'(c_q)) + $signed(SW'(k_q)) - $signed(SW'(LAG));
    if (nb < 0) begin
      nb = '0;
    end
    if (nb > $signed(SW'(b_q))) begin
      nb = $signed(SW'(b_q));
    end
    nbu     = nb[BW-1:0];
    nb_dist = b_q - nbu;
    fsel    = (nb_dist < BW'(FREQ_TAPS)) ? win_q[nb_dist[FIW-1:0]] : '0;
  end

  assign feeding    = (state_q == S_FEED) && (k_q < KW'(NMAX));
  assign sort_clear = (state_q == S_FEED) && (k_q == '0);
  assign mask_start = (state_q == S_FEED) && (k_q == KW'(KEND));
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  msmg_ram #(.WIDTH(MAG_BITS), .DEPTH(DEPTH)) u_hist (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  msmg_median #(.N(TIME_TAPS), .W(MAG_BITS)) u_tmed (
    .clk_i,
    .rst_ni,
    .clear_i    (sort_clear),
    .in_valid_i (tv_q),
    .in_data_i  (ram_rdata),
    .median_o   (h_med)
  );

  msmg_median #(.N(FREQ_TAPS), .W(MAG_BITS)) u_fmed (
    .clk_i,
    .rst_ni,
    .clear_i    (sort_clear),
    .in_valid_i (fv_q),
    .in_data_i  (fval_q),
    .median_o   (p_med)
  );

  msmg_mask #(.MAG_BITS(MAG_BITS)) u_mask (
    .clk_i,
    .rst_ni,
    .start_i       (mask_start),
    .h_i           (h_med),
    .p_i           (p_med),
    .tonal_gain_i  (tonal_gain_q),
    .attack_gain_i (attack_gain_q),
    .done_o        (mask_done),
    .res_o         (mres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q   <= BinCountRst;
      tonal_gain_q  <= GainRst;
      attack_gain_q <= GainRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBinCount:   bin_count_q   <= cfg_data_i[11:0];
        RegTonalGain:  tonal_gain_q  <= cfg_data_i;
        RegAttackGain: attack_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frequency window shift line and feed stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FREQ_TAPS; i++) begin
        win_q[i] <= '0;
      end
      tv_q <= 1'b0;
      fv_q <= 1'b0;
    end else begin
      if (accept) begin
        win_q[0] <= magnitude_i;
        for (int i = 1; i < FREQ_TAPS; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
      tv_q   <= feeding && (k_q < KW'(TIME_TAPS));
      fv_q   <= feeding && (k_q < KW'(FREQ_TAPS));
      fval_q <= fsel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bin_ctr_q   <= '0;
      slot_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            b_q     <= b_in;
            flush_q <= last_in;
            k_q     <= '0;
            if (!last_in) begin
              bin_ctr_q <= b_in + BW'(1);
              c_q       <= b_in - BW'(LAG);
              cend_q    <= b_in - BW'(LAG);
              if (b_in >= BW'(LAG)) begin
                state_q <= S_FEED;
              end
            end else begin
              bin_ctr_q <= '0;
              slot_q    <= (slot_q == SLW'(TIME_TAPS - 1)) ? '0 : slot_q + SLW'(1);
              c_q       <= (b_in >= BW'(LAG)) ? b_in - BW'(LAG) : '0;
              cend_q    <= b_in;
              state_q   <= S_FEED;
            end
          end
        end
        S_FEED: begin
          k_q <= k_q + KW'(1);
          if (mask_start) begin
            state_q <= S_MASK;
          end
        end
        S_MASK: begin
          if (mask_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            bin_q       <= c_ext[BinOutBits-1:0];
            outres_q    <= mres;
            last_q      <= flush_q && (c_q == b_q);
            if (c_q == cend_q) begin
              state_q <= S_IDLE;
            end else begin
              c_q     <= c_q + BW'(1);
              k_q     <= '0;
              state_q <= S_FEED;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign bin_index_o       = bin_q;
  assign gain_o            = outres_q.gain;
  assign tonal_fraction_o  = outres_q.tonal;
  assign attack_fraction_o = outres_q.attack;
  assign frame_last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_ctr_q < BW'(MAX_BINS - 1) || bin_ctr_q == BW'(MAX_BINS - 1))
    else $error("bin counter past frame limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLW'(TIME_TAPS - 1))
    else $error("history slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_done |-> state_q == S_MASK)
    else $error("mask result outside mask wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEED || state_q == S_MASK || state_q == S_OUT) |-> c_q <= cend_q)
    else $error("emit index past flush end");

endmodule

### sim/median_soft_mask_gain_unit_tb.sv
// testbench of median_soft_mask_gain_unit: magnitude beats in, per-bin gain beats checked
// against a scoreboard that predicts the time and frequency medians and the soft masks
// depends on msmg_pkg and median_soft_mask_gain_unit
`timescale 1ns / 1ps

module median_soft_mask_gain_unit_tb;
  import msmg_pkg::*;

  localparam int unsigned MaxBins  = MaxBinsDef;
  localparam int unsigned TimeTaps = TimeTapsDef;
  localparam int unsigned FreqTaps = FreqTapsDef;
  localparam int          Lag      = FreqTapsDef / 2;
  localparam int unsigned WatchLimit = 100000;
  localparam int unsigned SettleCycles = 150;
  localparam logic [CfgIdxBits-1:0] RegUnused = 2'd3;

  typedef struct {
    logic [BinOutBits-1:0] bin;
    logic [GainBits-1:0]   gain;
    logic [FracBits-1:0]   tonal;
    logic [FracBits-1:0]   attack;
    logic                  last;
  } gain_beat_t;

  class gain_scoreboard;
    bit [MagBitsDef-1:0] hist [MaxBins*TimeTaps];
    bit [MagBitsDef-1:0] win [FreqTaps];
    int unsigned slot;
    int unsigned counter;
    int unsigned bin_count = 2049;
    int unsigned tonal_gain = 16384;
    int unsigned attack_gain = 16384;
    gain_beat_t due[$];
    int unsigned errors;

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] v);
      case (idx)
        RegBinCount:   bin_count = v[11:0];
        RegTonalGain:  tonal_gain = v;
        RegAttackGain: attack_gain = v;
        default: ;
      endcase
    endfunction

    function int unsigned frame_len();
      if (bin_count < 1) return 1;
      if (bin_count > MaxBins) return MaxBins;
      return bin_count;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function longint unsigned median(longint unsigned v[$]);
      v.sort();
      return v[v.size()/2];
    endfunction

    function longint unsigned frac(longint unsigned num, longint unsigned den);
      logic [95:0] w;
      w = {32'd0, num} << 16;
      return w / den;
    endfunction

    function void predict_bin(int unsigned c, int unsigned b, bit last);
      longint unsigned tq[$];
      longint unsigned fq[$];
      int nb;
      longint unsigned h, p, h2, p2, t, a;
      longint acc;
      gain_beat_t r;
      for (int i = 0; i < TimeTaps; i++) tq.push_back(hist[c*TimeTaps+i]);
      for (int i = 0; i < FreqTaps; i++) begin
        nb = int'(c) + i - Lag;
        if (nb < 0) nb = 0;
        if (nb > int'(b)) nb = b;
        fq.push_back(win[int'(b) - nb]);
      end
      h = median(tq);
      p = median(fq);
      t = 0;
      a = 0;
      if (h != 0 || p != 0) begin
        h2 = h * h;
        p2 = p * p;
        t = frac(h2, h2 + 4 * p2);
        a = frac(p2, p2 + 4 * h2);
        if (t > 65536) t = 65536;
        if (a > 65536 - t) a = 65536 - t;
      end
      acc = (longint'(1) << 30) + (longint'(tonal_gain) - 16384) * longint'(t)
          + (longint'(attack_gain) - 16384) * longint'(a);
      if (acc < 0) acc = 0;
      acc = (acc + 32768) >>> 16;
      if (acc > 65535) acc = 65535;
      r.bin = c[11:0];
      r.gain = acc[15:0];
      r.tonal = (t > 65535) ? 16'hFFFF : t[15:0];
      r.attack = (a > 65535) ? 16'hFFFF : a[15:0];
      r.last = last;
      due.push_back(r);
    endfunction

    function void note_bin(logic [MagBitsDef-1:0] mag);
      int unsigned n, b, first;
      bit last;
      n = frame_len();
      b = counter;
      if (b >= MaxBins) b = MaxBins - 1;
      last = (b + 1 >= n);
      for (int i = FreqTaps - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = mag;
      if (slot >= TimeTaps) slot = 0;
      hist[b*TimeTaps+slot] = mag;
      if (!last) begin
        if (b >= Lag) predict_bin(b - Lag, b, 1'b0);
        counter = b + 1;
      end else begin
        first = (b >= Lag) ? b - Lag : 0;
        for (int unsigned c = first; c <= b; c++) predict_bin(c, b, c == b);
        counter = 0;
        slot = (slot + 1) % TimeTaps;
      end
    endfunction

    function void check_beat(gain_beat_t got);
      gain_beat_t w;
      if (due.size() == 0) begin
        $display("%0t: unexpected beat bin %0d gain %0d", $time, got.bin, got.gain);
        errors++;
        return;
      end
      w = due.pop_front();
      if (got.bin !== w.bin) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, w.bin, got.bin);
        errors++;
      end
      if (got.gain !== w.gain) begin
        $display("%0t: gain bin %0d expected %0d actual %0d", $time, w.bin, w.gain, got.gain);
        errors++;
      end
      if (got.tonal !== w.tonal) begin
        $display("%0t: tonal_fraction bin %0d expected %0d actual %0d",
                 $time, w.bin, w.tonal, got.tonal);
        errors++;
      end
      if (got.attack !== w.attack) begin
        $display("%0t: attack_fraction bin %0d expected %0d actual %0d",
                 $time, w.bin, w.attack, got.attack);
        errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t: frame_last bin %0d expected %0b actual %0b",
                 $time, w.bin, w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = RegBinCount;
  logic [CfgBits-1:0]    cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [MagBitsDef-1:0] magnitude_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [BinOutBits-1:0] bin_index_o;
  logic [GainBits-1:0]   gain_o;
  logic [FracBits-1:0]   tonal_fraction_o;
  logic [FracBits-1:0]   attack_fraction_o;
  logic                  frame_last_o;

  gain_scoreboard sb = new;
  bit sending;
  int unsigned burst_left = 1;
  int unsigned rand_items;
  int unsigned stall_left;
  int unsigned stall_mode;
  int unsigned quiet_cycles;
  logic [MagBitsDef-1:0] tone_base [64];

  median_soft_mask_gain_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .magnitude_i       (magnitude_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bin_index_o       (bin_index_o),
    .gain_o            (gain_o),
    .tonal_fraction_o  (tonal_fraction_o),
    .attack_fraction_o (attack_fraction_o),
    .frame_last_o      (frame_last_o)
  );

  always #10 clk_i = ~clk_i;

  // result side: check accepted beats, stall in changing modes
  always @(posedge clk_i) begin
    gain_beat_t got;
    if (out_valid_o && out_ready_i) begin
      got.bin = bin_index_o;
      got.gain = gain_o;
      got.tonal = tonal_fraction_o;
      got.attack = attack_fraction_o;
      got.last = frame_last_o;
      sb.check_beat(got);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WatchLimit) begin
      $display("median_soft_mask_gain_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_bin(logic [MagBitsDef-1:0] mag);
    in_valid_i <= 1'b1;
    magnitude_i <= mag;
    sending = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_bin(mag);
    if (--burst_left == 0) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
  endtask

  // hold input until every expected beat is back, then let the pipeline drain
  task automatic settle();
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [MagBitsDef-1:0] pick_mag(int unsigned mode, int unsigned pos);
    case (mode)
      0: return MagBitsDef'($urandom());
      1: return MagBitsDef'($urandom_range(0, 15));
      2: return tone_base[pos % 64] + MagBitsDef'($urandom_range(0, 255));
      default: return ($urandom_range(0, 7) == 0)
                      ? 24'hFFFFFF - MagBitsDef'($urandom_range(0, 4095))
                      : MagBitsDef'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [CfgBits-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return GainRst;
      default: return CfgBits'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned mode;
    logic [11:0] n;
    foreach (tone_base[i]) tone_base[i] = MagBitsDef'($urandom());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero frame shorter than the lag: both medians zero
    cfg_write(RegBinCount, 16'd3);
    repeat (3) send_bin('0);
    settle();
    cfg_write(RegTonalGain, 16'h0000);
    cfg_write(RegAttackGain, 16'hFFFF);
    cfg_write(RegBinCount, 16'd9);
    send_bin(24'hFFFFFF);
    send_bin(24'h000000);
    send_bin(24'hFFFFFF);
    send_bin(24'hAAAAAA);
    send_bin(24'h555555);
    send_bin(24'h000001);
    send_bin(24'hFFFFFE);
    send_bin(24'h800000);
    send_bin(24'h7FFFFF);
    settle();
    // zero length acts as one bin
    cfg_write(RegBinCount, 16'd0);
    send_bin(24'h123456);
    settle();
    // length lowered in the middle of a frame
    cfg_write(RegBinCount, 16'd12);
    for (int i = 0; i < 10; i++) send_bin(MagBitsDef'($urandom()));
    settle();
    cfg_write(RegBinCount, 16'd6);
    send_bin(MagBitsDef'($urandom()));
    settle();
    cfg_write(RegUnused, 16'hBEEF);

    while (rand_items < 300) begin
      settle();
      case ($urandom_range(0, 6))
        0: n = 12'($urandom_range(0, 8));
        1: n = 12'($urandom_range(41, 80));
        default: n = 12'($urandom_range(9, 40));
      endcase
      cfg_write(RegBinCount, {4'($urandom()), n});
      cfg_write(RegTonalGain, pick_gain());
      cfg_write(RegAttackGain, pick_gain());
      if ($urandom_range(0, 4) == 0) cfg_write(RegUnused, CfgBits'($urandom()));
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(2, 3)) begin
        for (int unsigned k = 0, len = sb.frame_len(); k < len; k++) begin
          send_bin(pick_mag(mode, k));
          rand_items++;
        end
      end
    end

    // length above the maximum keeps the frame open, a lower length then ends it
    settle();
    cfg_write(RegBinCount, 16'h0FFF);
    cfg_write(RegTonalGain, 16'hFFFF);
    cfg_write(RegAttackGain, 16'h0000);
    for (int unsigned k = 0; k < 120; k++) send_bin(pick_mag(k % 4, k));
    settle();
    cfg_write(RegBinCount, 16'd9);
    send_bin(pick_mag(0, 0));
    settle();

    if (sb.errors == 0) begin
      $display("median_soft_mask_gain_unit_tb: done, clean");
    end else begin
      $display("median_soft_mask_gain_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### median_soft_mask_gain_unit.f
design/msmg_pkg.sv
design/msmg_ram.sv
design/msmg_sort_cell.sv
design/msmg_median.sv
design/msmg_mask.sv
design/median_soft_mask_gain_unit.sv
sim/median_soft_mask_gain_unit_tb.sv
